[rtl/core/sorted_integer_set_unit_assert.svh]
// ============================================================================
// Sorted integer set unit: assertion macros
// Shared concurrent assertion forms, clocked on clk_i and disabled in reset.
// ============================================================================
`ifndef SORTED_INTEGER_SET_UNIT_ASSERT_SVH
`define SORTED_INTEGER_SET_UNIT_ASSERT_SVH

// Same-cycle implication.
`define SIS_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("sorted integer set assertion failed");

// Next-cycle implication.
`define SIS_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("sorted integer set assertion failed");

`endif

[rtl/core/sis_pkg.sv]
// ============================================================================
// Sorted integer set package
// Sizes, request codes and the item and control structs of the set unit.
// ============================================================================
package sis_pkg;

  localparam int CAPACITY   = 64;
  localparam int VALUE_BITS = 16;
  localparam int POS_W      = $clog2(CAPACITY);
  localparam int CNT_W      = $clog2(CAPACITY + 1);

  typedef enum logic [1:0] {
    REQ_CLEAR  = 2'd0,
    REQ_ADD    = 2'd1,
    REQ_LOOKUP = 2'd2
  } req_type_e;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [15:0] value;
  } sis_req_t;

  typedef struct packed {
    logic             found;
    logic [POS_W-1:0] position;
    logic             inserted;
    logic             overflow;
    logic [CNT_W-1:0] member_count;
  } sis_rsp_t;

  // Broadcast to every cell of the chain.
  typedef struct packed {
    logic                  shift_en;
    logic [VALUE_BITS-1:0] key;
  } sis_cell_ctl_t;

  // Where a cell stands relative to the member count.
  typedef struct packed {
    logic valid;  // cell holds a member
    logic slot;   // cell is a member or the first free place
  } sis_cell_loc_t;

endpackage

[rtl/core/sorted_integer_set_unit.sv]
// ============================================================================
// Sorted integer set unit
// Ordered set of distinct values held in a chain of compare-and-shift cells.
// ============================================================================
//
//   Channel   Ports                    Handshake
//   -------   ----------------------   ------------------------------------
//   request   start, busy, req_i       taken when start is high, busy low
//   result    done_o, rsp_o            done_o high for one cycle per item
//
// For every item, the accepting edge latches the request, and
// in the following busy cycle all cells compare their member with the key
// in parallel, the match encoder resolves found and position, and on an add
// the larger members move up one cell while the key drops into its place.
// The result is registered at the busy cycle's end and shown with done_o for one
// cycle, during which busy is already low, so a new item can be taken then.
// Reset empties the set by clearing the member count; the cell contents are
// not cleared, since a cell above the count is never read.
// The receiver has no way to stall results, so no result is ever held back.
//
module sorted_integer_set_unit (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  input  sis_pkg::sis_req_t req_i,
  output logic              busy,
  output logic              done_o,
  output sis_pkg::sis_rsp_t rsp_o
);
  import sis_pkg::*;

  // Latched request, held through the busy cycle.
  sis_req_t              req_q;
  logic                  busy_q;
  logic                  done_q;
  sis_rsp_t              rsp_q;
  sis_rsp_t              rsp_d;
  logic [CNT_W-1:0]      count_q;
  logic [CNT_W-1:0]      count_d;

  logic                  accept;
  logic                  full;
  logic                  hit;
  logic [POS_W-1:0]      hit_pos;
  sis_cell_ctl_t         cell_ctl;

  logic [CAPACITY-1:0]   cell_gt;
  logic [CAPACITY-1:0]   cell_eq;
  logic [VALUE_BITS-1:0] cell_data [CAPACITY];

  assign accept = start && !busy_q;
  assign full   = (count_q == CNT_W'(CAPACITY));

  // The chain acts on the key only during the busy cycle; an add of a new value
  // into a set with room shifts the chain.
  always_comb begin
    cell_ctl.key      = req_q.value[VALUE_BITS-1:0];
    cell_ctl.shift_en = busy_q && (req_type_e'(req_q.req_type) == REQ_ADD) && !hit && !full;
  end

  // The cell chain. Cell k holds a member while k is below the count, and
  // cell number count is the free place an insertion may fill.
  for (genvar k = 0; k < CAPACITY; k++) begin : g_cell
    sis_cell_loc_t         loc;
    logic                  left_gt;
    logic [VALUE_BITS-1:0] left_data;

    assign loc.valid = (count_q > CNT_W'(k));
    assign loc.slot  = (count_q >= CNT_W'(k));

    if (k == 0) begin : g_head
      assign left_gt   = 1'b0;
      assign left_data = '0;
    end else begin : g_link
      assign left_gt   = cell_gt[k-1];
      assign left_data = cell_data[k-1];
    end

    sis_cell u_cell (
      .clk_i       (clk_i),
      .ctl_i       (cell_ctl),
      .loc_i       (loc),
      .left_gt_i   (left_gt),
      .left_data_i (left_data),
      .gt_o        (cell_gt[k]),
      .eq_o        (cell_eq[k]),
      .data_o      (cell_data[k])
    );
  end

  sis_encode u_encode (
    .eq_i    (cell_eq),
    .found_o (hit),
    .pos_o   (hit_pos)
  );

  // Result and new count for the item in its busy cycle. An unknown request
  // code changes nothing and reports only the count.
  always_comb begin
    rsp_d    = '0;
    count_d  = count_q;
    unique case (req_type_e'(req_q.req_type))
      REQ_CLEAR: begin
        count_d = '0;
      end
      REQ_ADD: begin
        if (hit) begin
          rsp_d.found    = 1'b1;
          rsp_d.position = hit_pos;
        end else if (full) begin
          rsp_d.overflow = 1'b1;
        end else begin
          rsp_d.inserted = 1'b1;
          count_d        = count_q + CNT_W'(1);
        end
      end
      REQ_LOOKUP: begin
        rsp_d.found    = hit;
        rsp_d.position = hit_pos;
      end
      default: begin
      end
    endcase
    rsp_d.member_count = count_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q  <= 1'b0;
      done_q  <= 1'b0;
      count_q <= '0;
    end else begin
      busy_q <= accept;
      done_q <= busy_q;
      if (busy_q) begin
        count_q <= count_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      req_q <= req_i;
    end
    if (busy_q) begin
      rsp_q <= rsp_d;
    end
  end

  assign busy   = busy_q;
  assign done_o = done_q;
  assign rsp_o  = rsp_q;

`include "sorted_integer_set_unit_assert.svh"

  `SIS_ASSERT_IMP(a_count_bounded, 1'b1, count_q <= CNT_W'(CAPACITY))
  `SIS_ASSERT_NXT(a_busy_one_cycle, busy_q, !busy_q && done_q)
  `SIS_ASSERT_IMP(a_done_after_busy, done_q, $past(busy_q))
  `SIS_ASSERT_IMP(a_ins_ovf_excl, done_q, !(rsp_q.inserted && rsp_q.overflow))
  `SIS_ASSERT_IMP(a_ins_counts, done_q && rsp_q.inserted, count_q == $past(count_q) + CNT_W'(1))

endmodule

[rtl/core/sis_cell.sv]
// ============================================================================
// Sorted integer set cell
// Holds one member, compares it with the key and shifts in from its left.
// ============================================================================
module sis_cell (
  input  logic                          clk_i,
  input  sis_pkg::sis_cell_ctl_t        ctl_i,
  input  sis_pkg::sis_cell_loc_t        loc_i,
  input  logic                          left_gt_i,
  input  logic [sis_pkg::VALUE_BITS-1:0] left_data_i,
  output logic                          gt_o,
  output logic                          eq_o,
  output logic [sis_pkg::VALUE_BITS-1:0] data_o
);
  import sis_pkg::*;

  logic [VALUE_BITS-1:0] data_q;
  logic [VALUE_BITS-1:0] data_d;
  logic                  wr_en;

  assign gt_o   = loc_i.valid && (data_q > ctl_i.key);
  assign eq_o   = loc_i.valid && (data_q == ctl_i.key);
  assign data_o = data_q;

  // A larger member moves up one place; the cell where the chain of larger
  // members starts, or the free place if there is none, takes the key itself.
  assign wr_en  = ctl_i.shift_en && loc_i.slot && (gt_o || !loc_i.valid);
  assign data_d = left_gt_i ? left_data_i : ctl_i.key;

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      data_q <= data_d;
    end
  end

endmodule

[rtl/core/sis_encode.sv]
// ============================================================================
// Sorted integer set match encoder
// Turns the equality vector of the cells, at most one-hot, into found and position.
// ============================================================================
module sis_encode (
  input  logic [sis_pkg::CAPACITY-1:0] eq_i,
  output logic                         found_o,
  output logic [sis_pkg::POS_W-1:0]    pos_o
);
  import sis_pkg::*;

  assign found_o = |eq_i;

  // Members are distinct, so at most one bit is set and an OR of indexes works.
  always_comb begin
    pos_o = '0;
    for (int k = 0; k < CAPACITY; k++) begin
      if (eq_i[k]) begin
        pos_o = pos_o | POS_W'(k);
      end
    end
  end

endmodule
